@@ rtl/dsfp_pkg.sv @@
// ----------------------------------------------------------------------------
// dsfp_pkg
// Shared types and constants for the display serial frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dsfp_pkg;

  localparam logic [7:0] StartA    = 8'h5A;
  localparam logic [7:0] StartB    = 8'hA5;
  localparam logic [7:0] HdrBytes  = 8'd3;
  localparam logic [7:0] ByteMax   = 8'hFF;
  localparam logic [7:0] RccReset  = 8'h83;
  localparam int unsigned MaskW    = 10;

  typedef enum logic [1:0] {
    PH_START_A = 2'd0,
    PH_START_B = 2'd1,
    PH_LEN     = 2'd2,
    PH_DATA    = 2'd3
  } parse_phase_e;

  typedef enum logic [1:0] {
    KIND_VALUE   = 2'd0,
    KIND_DROPPED = 2'd1,
    KIND_ADDED   = 2'd2,
    KIND_FULL    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RSN_NOT_READ = 3'd0,
    RSN_EMPTY    = 3'd1,
    RSN_SHORT    = 3'd2,
    RSN_MISMATCH = 3'd3,
    RSN_TOO_MANY = 3'd4
  } drop_reason_e;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_CMD,
    CAP_ADDR_HI,
    CAP_ADDR_LO
  } cap_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_H0,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_CHECK,
    ST_VHI,
    ST_VLO,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic     take_byte;
    logic     take_watch;
    logic     rd_en;
    cap_sel_e cap_sel;
    logic     words_init;
    logic     load_drop;
    logic     load_value;
  } dsfp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic frame_end;
    logic drop;
    logic no_words;
    logic last_word;
  } dsfp_sts_t;

endpackage

`default_nettype wire

@@ rtl/dsfp_ifs.sv @@
// ----------------------------------------------------------------------------
// dsfp channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsfp_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  rx_byte;
  logic [15:0] watch_address;

  modport source (output valid, opcode, rx_byte, watch_address, input ready);
  modport sink   (input valid, opcode, rx_byte, watch_address, output ready);
endinterface

interface dsfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  drop_reason;
  logic [15:0] var_address;
  logic [15:0] var_value;
  logic [9:0]  match_mask;
  logic        last_of_frame;

  modport source (output valid, kind, drop_reason, var_address, var_value, match_mask,
                  last_of_frame, input ready);
  modport sink   (input valid, kind, drop_reason, var_address, var_value, match_mask,
                  last_of_frame, output ready);
endinterface

`default_nettype wire

@@ rtl/display_serial_frame_parser.sv @@
// ----------------------------------------------------------------------------
// display_serial_frame_parser
// Serial frame parser with watch-table matching, valid/ready channels.
// ----------------------------------------------------------------------------
// A received byte or a watch append is taken whenever the result register
// is free or being emptied. When a byte closes a frame the block stops
// taking items and walks its frame buffer: states H0 to H3 read the
// command, address and count bytes, the header is checked, then each
// 16-bit value is read high byte first and emitted, waiting while the
// result channel holds ready low. A dropped frame gives one result.
`default_nettype none

module display_serial_frame_parser #(
  parameter int unsigned WATCH_ENTRIES = 10,
  parameter int unsigned FRAME_BYTES   = 255,
  parameter int unsigned MAX_WORDS     = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  dsfp_in_if.sink           item_i,
  dsfp_out_if.source        result_o
);
  import dsfp_pkg::*;

  dsfp_cmd_t cmd;
  dsfp_sts_t sts;

  dsfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_opcode_i (item_i.opcode),
    .in_ready_o  (item_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dsfp_datapath #(
    .WATCH_ENTRIES (WATCH_ENTRIES),
    .FRAME_BYTES   (FRAME_BYTES),
    .MAX_WORDS     (MAX_WORDS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .rx_byte_i       (item_i.rx_byte),
    .watch_address_i (item_i.watch_address),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (result_o.ready),
    .out_valid_o     (result_o.valid),
    .kind_o          (result_o.kind),
    .drop_reason_o   (result_o.drop_reason),
    .var_address_o   (result_o.var_address),
    .var_value_o     (result_o.var_value),
    .match_mask_o    (result_o.match_mask),
    .last_of_frame_o (result_o.last_of_frame)
  );

endmodule

`default_nettype wire

@@ rtl/dsfp_datapath.sv @@
// ----------------------------------------------------------------------------
// dsfp_datapath
// Byte parser, frame buffer, watch table, header checks and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfp_datapath #(
  parameter int unsigned WATCH_ENTRIES = 10,
  parameter int unsigned FRAME_BYTES   = 255,
  parameter int unsigned MAX_WORDS     = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [7:0]                      cfg_wdata_i,
  input  logic [7:0]                      rx_byte_i,
  input  logic [15:0]                     watch_address_i,
  input  dsfp_pkg::dsfp_cmd_t             cmd_i,
  output dsfp_pkg::dsfp_sts_t             sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [1:0]                      kind_o,
  output logic [2:0]                      drop_reason_o,
  output logic [15:0]                     var_address_o,
  output logic [15:0]                     var_value_o,
  output logic [dsfp_pkg::MaskW-1:0]      match_mask_o,
  output logic                            last_of_frame_o
);
  import dsfp_pkg::*;

  localparam int unsigned AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned IW = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(WATCH_ENTRIES + 1);
  localparam logic [7:0] FrameBytesW = 8'(FRAME_BYTES);
  localparam logic [7:0] MaxWordsW   = 8'(MAX_WORDS);
  localparam logic [CW-1:0] WatchFull = CW'(WATCH_ENTRIES);

  // parser state
  parse_phase_e phase_q, phase_d;
  logic [7:0]   len_q, len_d;
  logic [7:0]   bc_q, bc_d;
  logic [7:0]   bc_inc;
  logic         frame_end;
  logic         mem_we;

  logic [7:0]   mem [FRAME_BYTES];
  logic [7:0]   rdata_q;
  logic [7:0]   ptr_q, ptr_d;

  logic [7:0]   rcc_q;
  logic [7:0]   hdr_cmd_q;
  logic [15:0]  start_q;
  logic [7:0]   val_hi_q;

  logic [7:0]   words_q, words_d;
  logic [15:0]  cur_addr_q, cur_addr_d;

  logic [15:0]  tbl_q [WATCH_ENTRIES];
  logic [CW-1:0] wc_q, wc_d;
  logic         tbl_full;
  logic         tbl_we;
  logic [WATCH_ENTRIES-1:0] hits;
  logic [MaskW-1:0] mask;

  logic         drop;
  drop_reason_e reason;
  logic [8:0]   cnt2;
  logic [8:0]   len_m1;

  logic         out_valid_q, out_valid_d;
  kind_e        kind_q;
  drop_reason_e reason_q;
  logic [15:0]  addr_q;
  logic [15:0]  value_q;
  logic [MaskW-1:0] mask_q;
  logic         last_q;
  logic         out_free;

  // byte parser
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    bc_d    = bc_q;
    mem_we  = 1'b0;
    bc_inc  = (bc_q != ByteMax) ? bc_q + 8'd1 : bc_q;
    frame_end = (phase_q == PH_DATA) && (bc_inc >= len_q);
    if (cmd_i.take_byte) begin
      unique case (phase_q)
        PH_START_A: begin
          if (rx_byte_i == StartA) phase_d = PH_START_B;
        end
        PH_START_B: begin
          phase_d = (rx_byte_i == StartB) ? PH_LEN : PH_START_A;
        end
        PH_LEN: begin
          len_d   = rx_byte_i;
          bc_d    = 8'd0;
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          mem_we = (bc_q < FrameBytesW);
          bc_d   = bc_inc;
          if (frame_end) phase_d = PH_START_A;
        end
        default: phase_d = PH_START_A;
      endcase
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.take_byte) ptr_d = 8'd0;
    else if (cmd_i.rd_en) ptr_d = ptr_q + 8'd1;
  end

  // watch table
  always_comb begin
    tbl_full = (wc_q >= WatchFull);
    tbl_we   = cmd_i.take_watch && !tbl_full;
    wc_d     = tbl_we ? wc_q + CW'(1) : wc_q;
  end

  always_comb begin
    for (int j = 0; j < int'(WATCH_ENTRIES); j++) begin
      hits[j] = (j < int'(wc_q)) && (tbl_q[j] == cur_addr_q);
    end
  end

  // entries past the mask width never show
  if (WATCH_ENTRIES >= MaskW) begin : g_mask_trunc
    assign mask = hits[MaskW-1:0];
  end else begin : g_mask_ext
    assign mask = MaskW'(hits);
  end

  // header checks; the count byte is still in the read register here
  always_comb begin
    cnt2   = {rdata_q, 1'b0};
    len_m1 = 9'(len_q) - 9'd1;
    drop   = 1'b1;
    reason = RSN_NOT_READ;
    if (len_q == 8'd0) begin
      reason = RSN_EMPTY;
    end else if (hdr_cmd_q != rcc_q) begin
      reason = RSN_NOT_READ;
    end else if (len_m1 < 9'(HdrBytes)) begin
      reason = RSN_SHORT;
    end else if (cnt2 != len_m1 - 9'(HdrBytes)) begin
      reason = RSN_MISMATCH;
    end else if ((rdata_q > MaxWordsW) || (len_q > FrameBytesW)) begin
      reason = RSN_TOO_MANY;
    end else begin
      drop = 1'b0;
    end
  end

  always_comb begin
    words_d    = words_q;
    cur_addr_d = cur_addr_q;
    if (cmd_i.words_init) begin
      words_d    = rdata_q;
      cur_addr_d = start_q;
    end else if (cmd_i.load_value) begin
      words_d    = words_q - 8'd1;
      cur_addr_d = cur_addr_q + 16'd1;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.take_watch || cmd_i.load_drop || cmd_i.load_value) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START_A;
      len_q       <= 8'd0;
      bc_q        <= 8'd0;
      ptr_q       <= 8'd0;
      wc_q        <= '0;
      rcc_q       <= RccReset;
      words_q     <= 8'd0;
      cur_addr_q  <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_q       <= len_d;
      bc_q        <= bc_d;
      ptr_q       <= ptr_d;
      wc_q        <= wc_d;
      words_q     <= words_d;
      cur_addr_q  <= cur_addr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) rcc_q <= cfg_wdata_i;
    end
  end

  // frame buffer, single write and single registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[bc_q[AW-1:0]] <= rx_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rdata_q <= mem[ptr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_q[wc_q[IW-1:0]] <= watch_address_i;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.cap_sel)
      CAP_CMD:     hdr_cmd_q     <= rdata_q;
      CAP_ADDR_HI: start_q[15:8] <= rdata_q;
      CAP_ADDR_LO: start_q[7:0]  <= rdata_q;
      default:     ;
    endcase
    // high value byte arrives while the low byte read is issued
    if (cmd_i.rd_en && cmd_i.cap_sel == CAP_NONE) val_hi_q <= rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_watch) begin
      kind_q   <= tbl_full ? KIND_FULL : KIND_ADDED;
      reason_q <= RSN_NOT_READ;
      addr_q   <= watch_address_i;
      value_q  <= 16'd0;
      mask_q   <= '0;
      last_q   <= 1'b0;
    end else if (cmd_i.load_drop) begin
      kind_q   <= KIND_DROPPED;
      reason_q <= reason;
      addr_q   <= 16'd0;
      value_q  <= 16'd0;
      mask_q   <= '0;
      last_q   <= 1'b0;
    end else if (cmd_i.load_value) begin
      kind_q   <= KIND_VALUE;
      reason_q <= RSN_NOT_READ;
      addr_q   <= cur_addr_q;
      value_q  <= {val_hi_q, rdata_q};
      mask_q   <= mask;
      last_q   <= (words_q == 8'd1);
    end
  end

  assign sts_o = '{
    out_free:  out_free,
    frame_end: frame_end,
    drop:      drop,
    no_words:  (rdata_q == 8'd0),
    last_word: (words_q == 8'd1)
  };

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign drop_reason_o   = reason_q;
  assign var_address_o   = addr_q;
  assign var_value_o     = value_q;
  assign match_mask_o    = mask_q;
  assign last_of_frame_o = last_q;

  a_watch_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= WatchFull)
    else $error("watch count past table size");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take_watch || cmd_i.load_drop || cmd_i.load_value) |-> out_free)
    else $error("result loaded over a pending beat");

  a_value_in_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_value |-> (words_q != 8'd0))
    else $error("value emitted past the word count");

endmodule

`default_nettype wire

@@ rtl/dsfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// dsfp_ctrl
// Sequencer: accepts items, then walks the frame buffer at frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_opcode_i,
  output logic                in_ready_o,
  input  dsfp_pkg::dsfp_sts_t sts_i,
  output dsfp_pkg::dsfp_cmd_t cmd_o
);
  import dsfp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        in_ready;
  logic        take_byte;

  assign in_ready  = (state_q == ST_IDLE) && sts_i.out_free;
  assign take_byte = in_valid_i && in_ready && !in_opcode_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (take_byte && sts_i.frame_end) state_d = ST_H0;
      ST_H0:    state_d = ST_H1;
      ST_H1:    state_d = ST_H2;
      ST_H2:    state_d = ST_H3;
      ST_H3:    state_d = ST_CHECK;
      ST_CHECK: begin
        if (sts_i.drop) begin
          if (sts_i.out_free) state_d = ST_IDLE;
        end else begin
          state_d = sts_i.no_words ? ST_IDLE : ST_VHI;
        end
      end
      ST_VHI:   state_d = ST_VLO;
      ST_VLO:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.last_word ? ST_IDLE : ST_VHI;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.cap_sel    = CAP_NONE;
    cmd_o.take_byte  = take_byte;
    cmd_o.take_watch = in_valid_i && in_ready && in_opcode_i;
    unique case (state_q)
      ST_IDLE:  ;
      ST_H0:    cmd_o.rd_en = 1'b1;
      ST_H1: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.cap_sel = CAP_CMD;
      end
      ST_H2: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.cap_sel = CAP_ADDR_HI;
      end
      ST_H3: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.cap_sel = CAP_ADDR_LO;
      end
      ST_CHECK: begin
        cmd_o.load_drop  = sts_i.drop && sts_i.out_free;
        cmd_o.words_init = !sts_i.drop;
      end
      ST_VHI:   cmd_o.rd_en = 1'b1;
      ST_VLO:   cmd_o.rd_en = 1'b1;
      ST_EMIT:  cmd_o.load_value = sts_i.out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = in_ready;

  a_frame_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_byte && sts_i.frame_end) |=> (state_q == ST_H0))
    else $error("frame end did not start the header walk");

  a_last_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && sts_i.out_free && sts_i.last_word) |=> (state_q == ST_IDLE))
    else $error("sequencer did not return after the last value");

endmodule

`default_nettype wire
